[src/htc_pkg.sv]
// ============================================================================
// htc_pkg - shared types and constants for the track command block
// Fixed-point constants, the arctangent table for the rotation pipeline,
// the register map and the configuration record.
// ============================================================================
package htc_pkg;

    // defaults handed to the top level parameters
    localparam int ROTATION_STEPS_DEF  = 16;
    localparam int ANGLE_FRAC_BITS_DEF = 13;

    // field and port widths
    localparam int FIELD_W      = 16;
    localparam int LIM_W        = 15;
    localparam int CFG_AW       = 4;
    localparam int CFG_DW       = 32;
    localparam int ATAN_ENTRIES = 24;

    // internal widths
    localparam int VEL_GUARD   = 8;
    localparam int WRAP_W      = 38;                    // offset angle before reduction
    localparam int ANG_W       = 33;                    // q30 angle in [-pi, pi]
    localparam int XW          = 28;                    // rotation datapath
    localparam int INV_W       = 31;                    // signed width of 1/K
    localparam int XPROD_W     = XW + INV_W;
    localparam int BODY_W      = 20;
    localparam int GAIN_W      = 16;
    localparam int RPROD_W     = ANG_W + GAIN_W + 1;
    localparam int RATE_W      = 24;
    localparam int BODY_SHIFT  = 30 + VEL_GUARD;
    localparam int RATE_SHIFT  = 26;

    // pipeline depths
    localparam int WRAP_STAGES  = 4;                    // one compare and subtract each
    localparam int HEAD_STAGES  = WRAP_STAGES + 3;      // offset, wrap, multiply, round
    localparam int CORDIC_EXTRA = 3;                    // fold, multiply, round

    // angle constants, q30 radians
    localparam logic signed [WRAP_W-1:0] PI_Q30      = 38'sd3373259426;
    localparam logic signed [WRAP_W-1:0] TWO_PI_Q30  = 38'sd6746518852;
    localparam logic signed [WRAP_W-1:0] WRAP_OFFSET =
        PI_Q30 + (TWO_PI_Q30 <<< (WRAP_STAGES - 1));
    localparam logic signed [ANG_W-1:0]  PI_ANG      = 33'sd3373259426;
    localparam logic signed [ANG_W-1:0]  HALF_PI_ANG = 33'sd1686629713;
    localparam logic signed [INV_W-1:0]  INV_GAIN_Q30 = 31'sd652032875;

    // register map
    typedef enum logic [CFG_AW-3:0] {
        REG_TARGET     = 2'd0,
        REG_GAIN       = 2'd1,
        REG_RATE_LIM   = 2'd2,
        REG_SPEED_LIM  = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic signed [FIELD_W-1:0] target_heading;
        logic [GAIN_W-1:0]         heading_gain;
        logic [LIM_W-1:0]          yaw_rate_limit;
        logic [LIM_W-1:0]          speed_limit;
    } t_cfg;

    localparam t_cfg CFG_RST = '{
        target_heading: 16'sd0,
        heading_gain:   16'd256,
        yaw_rate_limit: 15'd4096,
        speed_limit:    15'd4096
    };

    // arctangent of 2^-idx in q30 radians
    function automatic logic signed [ANG_W-1:0] atan_q30(input int idx);
        case (idx)
            0:       return 33'sd843314857;
            1:       return 33'sd497837830;
            2:       return 33'sd263043837;
            3:       return 33'sd133525159;
            4:       return 33'sd67021687;
            5:       return 33'sd33543516;
            6:       return 33'sd16775851;
            7:       return 33'sd8388437;
            8:       return 33'sd4194283;
            9:       return 33'sd2097149;
            10:      return 33'sd1048576;
            11:      return 33'sd524288;
            12:      return 33'sd262144;
            13:      return 33'sd131072;
            14:      return 33'sd65536;
            15:      return 33'sd32768;
            16:      return 33'sd16384;
            17:      return 33'sd8192;
            18:      return 33'sd4096;
            19:      return 33'sd2048;
            20:      return 33'sd1024;
            21:      return 33'sd512;
            22:      return 33'sd256;
            23:      return 33'sd128;
            default: return '0;
        endcase
    endfunction

    // sign-extend a 16-bit angle and scale it to q30
    function automatic logic signed [WRAP_W-1:0] to_q30(
        input logic signed [FIELD_W-1:0] a,
        input int                        shift
    );
        logic signed [WRAP_W-1:0] v_ext;
        v_ext = WRAP_W'(a);
        return v_ext <<< shift;
    endfunction

endpackage

[src/htc_in_if.sv]
// ============================================================================
// htc_in_if - command input channel
// Valid/ready channel carrying the pose yaw and the world-frame velocity.
// ============================================================================
interface htc_in_if import htc_pkg::*; ();

    logic                      valid;
    logic                      ready;
    logic signed [FIELD_W-1:0] pose_yaw;
    logic signed [FIELD_W-1:0] ref_vel_x;
    logic signed [FIELD_W-1:0] ref_vel_y;
    logic                      reference_valid;
    logic                      pose_valid;

    modport source (
        output valid, pose_yaw, ref_vel_x, ref_vel_y, reference_valid, pose_valid,
        input  ready
    );

    modport sink (
        input  valid, pose_yaw, ref_vel_x, ref_vel_y, reference_valid, pose_valid,
        output ready
    );

endinterface

[src/htc_out_if.sv]
// ============================================================================
// htc_out_if - command output channel
// Valid/ready channel carrying the body-frame speeds and the yaw rate.
// ============================================================================
interface htc_out_if import htc_pkg::*; ();

    logic                      valid;
    logic                      ready;
    logic signed [FIELD_W-1:0] body_vel_x;
    logic signed [FIELD_W-1:0] body_vel_y;
    logic signed [FIELD_W-1:0] yaw_rate_cmd;

    modport source (
        output valid, body_vel_x, body_vel_y, yaw_rate_cmd,
        input  ready
    );

    modport sink (
        input  valid, body_vel_x, body_vel_y, yaw_rate_cmd,
        output ready
    );

endinterface

[src/htc_cfg.sv]
// ============================================================================
// htc_cfg - configuration registers
// APB-style register file holding target heading, gain and the two limits.
// ============================================================================
module htc_cfg import htc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [CFG_DW-1:0] pwdata,
    output logic [CFG_DW-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign w_idx  = t_reg_idx'(paddr[CFG_AW-1:2]);
    assign w_wr   = psel & penable & pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    // register write on the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RST;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_TARGET:    r_cfg.target_heading <= pwdata[FIELD_W-1:0];
                REG_GAIN:      r_cfg.heading_gain   <= pwdata[GAIN_W-1:0];
                REG_RATE_LIM:  r_cfg.yaw_rate_limit <= pwdata[LIM_W-1:0];
                REG_SPEED_LIM: r_cfg.speed_limit    <= pwdata[LIM_W-1:0];
            endcase
        end
    end

    // read-back mux
    always_comb begin
        unique case (w_idx)
            REG_TARGET:    prdata = CFG_DW'(r_cfg.target_heading);
            REG_GAIN:      prdata = CFG_DW'(r_cfg.heading_gain);
            REG_RATE_LIM:  prdata = CFG_DW'(r_cfg.yaw_rate_limit);
            REG_SPEED_LIM: prdata = CFG_DW'(r_cfg.speed_limit);
        endcase
    end

endmodule

[src/htc_wrap.sv]
// ============================================================================
// htc_wrap - angle wrap pipeline
// Reduces an offset q30 angle to [-pi, pi) by binary compare-and-subtract
// of multiples of two pi, one multiple per stage, with a sideband alongside.
// ============================================================================
module htc_wrap import htc_pkg::*; #(
    parameter int SIDE_W = 1
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  logic signed [WRAP_W-1:0] i_u,
    input  logic [SIDE_W-1:0]        i_side,
    output logic signed [ANG_W-1:0]  o_angle,
    output logic [SIDE_W-1:0]        o_side
);

    logic signed [WRAP_W-1:0] r_u    [WRAP_STAGES];
    logic signed [WRAP_W-1:0] n_u    [WRAP_STAGES];
    logic signed [WRAP_W-1:0] w_in   [WRAP_STAGES];
    logic [SIDE_W-1:0]        r_side [WRAP_STAGES];

    // stage inputs
    always_comb begin
        w_in[0] = i_u;
        for (int k = 1; k < WRAP_STAGES; k++) begin
            w_in[k] = r_u[k-1];
        end
    end

    // one multiple of two pi per stage, largest first; last stage removes the offset
    always_comb begin
        logic signed [WRAP_W-1:0] v_step;
        for (int k = 0; k < WRAP_STAGES; k++) begin
            v_step = TWO_PI_Q30 <<< (WRAP_STAGES - 1 - k);
            if (k == WRAP_STAGES - 1) begin
                n_u[k] = (w_in[k] >= v_step) ? w_in[k] - v_step - PI_Q30
                                             : w_in[k] - PI_Q30;
            end else begin
                n_u[k] = (w_in[k] >= v_step) ? w_in[k] - v_step : w_in[k];
            end
        end
    end

    // angle registers
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < WRAP_STAGES; k++) begin
                r_u[k] <= n_u[k];
            end
        end
    end

    // sideband travels with the angle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < WRAP_STAGES; k++) begin
                r_side[k] <= '0;
            end
        end else if (i_en) begin
            r_side[0] <= i_side;
            for (int k = 1; k < WRAP_STAGES; k++) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    assign o_angle = ANG_W'(r_u[WRAP_STAGES-1]);
    assign o_side  = r_side[WRAP_STAGES-1];

endmodule

[src/htc_cordic.sv]
// ============================================================================
// htc_cordic - body-frame rotation pipeline
// Folds the rotation into a half turn, runs one CORDIC micro-rotation per
// stage, removes the CORDIC gain and rounds back to 1/4096 units.
// ============================================================================
module htc_cordic import htc_pkg::*; #(
    parameter int ROTATION_STEPS = ROTATION_STEPS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic                      i_valid,
    input  logic                      i_ok,
    input  logic signed [ANG_W-1:0]   i_yaw,
    input  logic signed [FIELD_W-1:0] i_vel_x,
    input  logic signed [FIELD_W-1:0] i_vel_y,
    output logic                      o_valid,
    output logic signed [BODY_W-1:0]  o_body_x,
    output logic signed [BODY_W-1:0]  o_body_y
);

    localparam logic signed [XPROD_W-1:0] BODY_HALF = XPROD_W'(1) <<< (BODY_SHIFT - 1);

    // index 0 is the fold stage, index k+1 the output of micro-rotation k
    logic signed [XW-1:0]    r_x  [ROTATION_STEPS+1];
    logic signed [XW-1:0]    r_y  [ROTATION_STEPS+1];
    logic signed [ANG_W-1:0] r_z  [ROTATION_STEPS+1];
    logic                    r_v  [ROTATION_STEPS+1];
    logic                    r_ok [ROTATION_STEPS+1];
    logic signed [XW-1:0]    n_x  [ROTATION_STEPS+1];
    logic signed [XW-1:0]    n_y  [ROTATION_STEPS+1];
    logic signed [ANG_W-1:0] n_z  [ROTATION_STEPS+1];
    logic                    n_v  [ROTATION_STEPS+1];
    logic                    n_ok [ROTATION_STEPS+1];

    logic signed [XPROD_W-1:0] r_px, r_py, n_px, n_py;
    logic                      r_mv, r_mok;
    logic signed [BODY_W-1:0]  r_bx, r_by, n_bx, n_by;
    logic                      r_bv;

    // fold and micro-rotations
    always_comb begin
        logic signed [XW-1:0]    v_x, v_y;
        logic signed [ANG_W-1:0] v_z;
        v_z = -i_yaw;
        v_x = XW'(i_vel_x) <<< VEL_GUARD;
        v_y = XW'(i_vel_y) <<< VEL_GUARD;
        // half turn: negate the vector and move the angle by pi
        if (v_z > HALF_PI_ANG) begin
            v_x = -v_x;
            v_y = -v_y;
            v_z = v_z - PI_ANG;
        end else if (v_z < -HALF_PI_ANG) begin
            v_x = -v_x;
            v_y = -v_y;
            v_z = v_z + PI_ANG;
        end
        n_x[0]  = v_x;
        n_y[0]  = v_y;
        n_z[0]  = v_z;
        n_v[0]  = i_valid;
        n_ok[0] = i_ok;
        for (int k = 0; k < ROTATION_STEPS; k++) begin
            if (!r_z[k][ANG_W-1]) begin
                n_x[k+1] = r_x[k] - (r_y[k] >>> k);
                n_y[k+1] = r_y[k] + (r_x[k] >>> k);
                n_z[k+1] = r_z[k] - atan_q30(k);
            end else begin
                n_x[k+1] = r_x[k] + (r_y[k] >>> k);
                n_y[k+1] = r_y[k] - (r_x[k] >>> k);
                n_z[k+1] = r_z[k] + atan_q30(k);
            end
            n_v[k+1]  = r_v[k];
            n_ok[k+1] = r_ok[k];
        end
    end

    // gain removal and rounding to nearest
    always_comb begin
        n_px = XPROD_W'(r_x[ROTATION_STEPS]) * XPROD_W'(INV_GAIN_Q30);
        n_py = XPROD_W'(r_y[ROTATION_STEPS]) * XPROD_W'(INV_GAIN_Q30);
        n_bx = r_mok ? BODY_W'((r_px + BODY_HALF) >>> BODY_SHIFT) : '0;
        n_by = r_mok ? BODY_W'((r_py + BODY_HALF) >>> BODY_SHIFT) : '0;
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k <= ROTATION_STEPS; k++) begin
                r_x[k]  <= n_x[k];
                r_y[k]  <= n_y[k];
                r_z[k]  <= n_z[k];
                r_ok[k] <= n_ok[k];
            end
            r_px  <= n_px;
            r_py  <= n_py;
            r_mok <= r_ok[ROTATION_STEPS];
            r_bx  <= n_bx;
            r_by  <= n_by;
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= ROTATION_STEPS; k++) begin
                r_v[k] <= 1'b0;
            end
            r_mv <= 1'b0;
            r_bv <= 1'b0;
        end else if (i_en) begin
            for (int k = 0; k <= ROTATION_STEPS; k++) begin
                r_v[k] <= n_v[k];
            end
            r_mv <= r_v[ROTATION_STEPS];
            r_bv <= r_mv;
        end
    end

    assign o_valid  = r_bv;
    assign o_body_x = r_bx;
    assign o_body_y = r_by;

endmodule

[src/htc_heading.sv]
// ============================================================================
// htc_heading - heading error and proportional yaw rate
// Wraps the error to the target heading, scales it by the gain, rounds, and
// delays the result to line up with the rotation pipeline.
// ============================================================================
module htc_heading import htc_pkg::*; #(
    parameter int ROTATION_STEPS  = ROTATION_STEPS_DEF,
    parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic                      i_ok,
    input  logic signed [ANG_W-1:0]   i_yaw,
    input  logic signed [FIELD_W-1:0] i_target,
    input  logic [GAIN_W-1:0]         i_gain,
    output logic signed [RATE_W-1:0]  o_rate
);

    localparam int Q30_SHIFT = 30 - ANGLE_FRAC_BITS;
    localparam int DELAY     = ROTATION_STEPS + CORDIC_EXTRA - HEAD_STAGES;
    localparam logic signed [RPROD_W-1:0] RATE_HALF = RPROD_W'(1) <<< (RATE_SHIFT - 1);

    logic signed [WRAP_W-1:0]  r_eu;
    logic                      r_eok;
    logic signed [ANG_W-1:0]   w_err;
    logic                      w_ok;
    logic signed [RPROD_W-1:0] r_p, n_p;
    logic                      r_pok;
    logic signed [RATE_W-1:0]  r_rate, n_rate;
    logic signed [RATE_W-1:0]  r_dly [DELAY];

    // raw error, offset for the wrap stages
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_eu  <= to_q30(i_target, Q30_SHIFT) - WRAP_W'(i_yaw) + WRAP_OFFSET;
            r_eok <= i_ok;
        end
    end

    htc_wrap #(
        .SIDE_W (1)
    ) u_err_wrap (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (i_en),
        .i_u     (r_eu),
        .i_side  (r_eok),
        .o_angle (w_err),
        .o_side  (w_ok)
    );

    // gain product and rounding to nearest
    always_comb begin
        n_p    = RPROD_W'(w_err) * RPROD_W'($signed({1'b0, i_gain}));
        n_rate = r_pok ? RATE_W'((r_p + RATE_HALF) >>> RATE_SHIFT) : '0;
    end

    // multiply, round and alignment delay
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p      <= n_p;
            r_pok    <= w_ok;
            r_rate   <= n_rate;
            r_dly[0] <= r_rate;
            for (int k = 1; k < DELAY; k++) begin
                r_dly[k] <= r_dly[k-1];
            end
        end
    end

    assign o_rate = r_dly[DELAY-1];

endmodule

[src/holonomic_track_command.sv]
// ============================================================================
// holonomic_track_command - body-frame velocity and heading command
// Rotates a world-frame velocity reference into the body frame and forms a
// clamped proportional yaw rate toward the configured heading.
// ============================================================================
// One command is accepted every clock cycle unless the pipeline holds. Each
// result passes through one input register, four yaw wrap stages, a fold
// stage, one stage per CORDIC micro-rotation, a gain multiply, a rounding
// stage and the output register; the heading path runs alongside in a
// matching delay. The whole pipeline holds while the output register is full
// and not taken, so the input is ready whenever the output is empty or being
// taken. When either valid flag of a command is low its result is all zeros.
// Registers are written over APB at byte addresses 0, 4, 8 and 12 and should
// only change while no command is in flight.
// ============================================================================
module holonomic_track_command import htc_pkg::*; #(
    parameter int ROTATION_STEPS  = ROTATION_STEPS_DEF,
    parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [CFG_DW-1:0] pwdata,
    output logic [CFG_DW-1:0] prdata,
    output logic              pready,
    htc_in_if.sink            i_ref,
    htc_out_if.source         o_cmd
);

    localparam int Q30_SHIFT = 30 - ANGLE_FRAC_BITS;
    localparam int SIDE_W    = 2 + 2 * FIELD_W;

    t_cfg                      w_cfg;
    logic                      w_en;
    logic                      r_in_valid;
    logic                      r_in_ok;
    logic signed [FIELD_W-1:0] r_in_x, r_in_y;
    logic signed [WRAP_W-1:0]  r_in_u;
    logic signed [ANG_W-1:0]   w_yaw;
    logic [SIDE_W-1:0]         w_side;
    logic                      w_cd_valid;
    logic signed [BODY_W-1:0]  w_bx, w_by;
    logic signed [RATE_W-1:0]  w_rate;
    logic                      r_out_valid;
    logic signed [FIELD_W-1:0] r_out_x, r_out_y, r_out_rate;

    // symmetric clamp to a positive limit
    function automatic logic signed [FIELD_W-1:0] clamp(
        input logic signed [RATE_W-1:0] v,
        input logic [LIM_W-1:0]         lim
    );
        logic signed [RATE_W-1:0] v_lim;
        v_lim = $signed(RATE_W'(lim));
        if (v > v_lim) begin
            return FIELD_W'(v_lim);
        end else if (v < -v_lim) begin
            return FIELD_W'(-v_lim);
        end
        return FIELD_W'(v);
    endfunction

    htc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // pipeline advances unless a finished result waits
    assign w_en        = !r_out_valid || o_cmd.ready;
    assign i_ref.ready = w_en;

    // input register: yaw scaled to q30 and offset for the wrap stages
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_in_ok <= i_ref.reference_valid & i_ref.pose_valid;
            r_in_x  <= i_ref.ref_vel_x;
            r_in_y  <= i_ref.ref_vel_y;
            r_in_u  <= to_q30(i_ref.pose_yaw, Q30_SHIFT) + WRAP_OFFSET;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_en) begin
            r_in_valid <= i_ref.valid;
        end
    end

    // yaw wrap with the rest of the command alongside
    htc_wrap #(
        .SIDE_W (SIDE_W)
    ) u_yaw_wrap (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_u     (r_in_u),
        .i_side  ({r_in_valid, r_in_ok, r_in_x, r_in_y}),
        .o_angle (w_yaw),
        .o_side  (w_side)
    );

    htc_cordic #(
        .ROTATION_STEPS (ROTATION_STEPS)
    ) u_cordic (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_valid  (w_side[SIDE_W-1]),
        .i_ok     (w_side[SIDE_W-2]),
        .i_yaw    (w_yaw),
        .i_vel_x  (w_side[2*FIELD_W-1:FIELD_W]),
        .i_vel_y  (w_side[FIELD_W-1:0]),
        .o_valid  (w_cd_valid),
        .o_body_x (w_bx),
        .o_body_y (w_by)
    );

    htc_heading #(
        .ROTATION_STEPS  (ROTATION_STEPS),
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
    ) u_heading (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_ok     (w_side[SIDE_W-2]),
        .i_yaw    (w_yaw),
        .i_target (w_cfg.target_heading),
        .i_gain   (w_cfg.heading_gain),
        .o_rate   (w_rate)
    );

    // output register with the limits applied
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_x    <= clamp(RATE_W'(w_bx), w_cfg.speed_limit);
            r_out_y    <= clamp(RATE_W'(w_by), w_cfg.speed_limit);
            r_out_rate <= clamp(w_rate, w_cfg.yaw_rate_limit);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_cd_valid;
        end
    end

    assign o_cmd.valid        = r_out_valid;
    assign o_cmd.body_vel_x   = r_out_x;
    assign o_cmd.body_vel_y   = r_out_y;
    assign o_cmd.yaw_rate_cmd = r_out_rate;

endmodule

[bench/tb_top.sv]
`timescale 1ns / 1ps
// ============================================================================
// tb_top - testbench for the holonomic track command block
// Drives pose and velocity commands through valid/ready channels with random
// idling on both sides, writes the heading, gain and limit registers over APB
// between phases, and checks every result field by field against its directed
// row or a behavioural model of the CORDIC rotation and the heading controller.
// ============================================================================
module tb_top;
    import htc_pkg::*;

    localparam int     ROT_STEPS    = ROTATION_STEPS_DEF;
    localparam int     FRAC_BITS    = ANGLE_FRAC_BITS_DEF;
    localparam int     DRAIN_CYCLES = ROTATION_STEPS_DEF + 9 + 16;
    localparam longint PI_Q         = 64'sd3373259426;
    localparam longint HALF_PI_Q    = 64'sd1686629713;
    localparam longint TWO_PI_Q     = 64'sd6746518852;
    localparam longint INV_K_Q30    = 64'sd652032875;
    localparam int     DIR_ROWS     = 20;

    // arctangent of 2^-i, q30 radians
    localparam longint ATAN_STEP [24] = '{
        843314857, 497837830, 263043837, 133525159,
        67021687, 33543516, 16775851, 8388437,
        4194283, 2097149, 1048576, 524288,
        262144, 131072, 65536, 32768,
        16384, 8192, 4096, 2048,
        1024, 512, 256, 128
    };

    typedef struct packed {
        logic signed [FIELD_W-1:0] pose_yaw;
        logic signed [FIELD_W-1:0] ref_vel_x;
        logic signed [FIELD_W-1:0] ref_vel_y;
        logic                      reference_valid;
        logic                      pose_valid;
    } t_ref_cmd;

    typedef struct packed {
        logic signed [FIELD_W-1:0] body_vel_x;
        logic signed [FIELD_W-1:0] body_vel_y;
        logic signed [FIELD_W-1:0] yaw_rate_cmd;
    } t_body_cmd;

    typedef struct packed {
        t_ref_cmd  cmd;
        logic      typed;
        t_body_cmd want;
    } t_dir_row;

    // directed rows, all under the reset register values
    localparam t_dir_row DIRECTED [DIR_ROWS] = '{
        // still vehicle, zero reference
        '{'{16'sd0, 16'sd0, 16'sd0, 1'b1, 1'b1}, 1'b1, '{16'sd0, 16'sd0, 16'sd0}},
        // full-scale speeds clamp to the limit
        '{'{16'sd0, 16'sd32767, -16'sd32768, 1'b1, 1'b1}, 1'b1,
          '{16'sd4096, -16'sd4096, 16'sd0}},
        '{'{16'sd0, -16'sd32768, 16'sd32767, 1'b1, 1'b1}, 1'b1,
          '{-16'sd4096, 16'sd4096, 16'sd0}},
        // invalid reference or pose gives all zeros
        '{'{16'sd1000, 16'sd30000, -16'sd30000, 1'b0, 1'b1}, 1'b1,
          '{16'sd0, 16'sd0, 16'sd0}},
        '{'{16'sd1000, 16'sd30000, -16'sd30000, 1'b1, 1'b0}, 1'b1,
          '{16'sd0, 16'sd0, 16'sd0}},
        '{'{-16'sd32768, -16'sd32768, -16'sd32768, 1'b0, 1'b0}, 1'b1,
          '{16'sd0, 16'sd0, 16'sd0}},
        // heading error wraps the short way round near a half turn
        '{'{16'sd25736, 16'sd0, 16'sd0, 1'b1, 1'b1}, 1'b1, '{16'sd0, 16'sd0, 16'sd4096}},
        '{'{-16'sd25736, 16'sd0, 16'sd0, 1'b1, 1'b1}, 1'b1, '{16'sd0, 16'sd0, -16'sd4096}},
        // either side of the quarter-turn fold
        '{'{16'sd12867, 16'sd1000, 16'sd500, 1'b1, 1'b1}, 1'b0, '0},
        '{'{16'sd12868, 16'sd1000, 16'sd500, 1'b1, 1'b1}, 1'b0, '0},
        '{'{-16'sd12868, -16'sd2000, 16'sd1500, 1'b1, 1'b1}, 1'b0, '0},
        '{'{-16'sd12867, 16'sd300, -16'sd3000, 1'b1, 1'b1}, 1'b0, '0},
        // yaw beyond the stated range wraps modulo a full turn; then assorted rows
        '{'{16'sd32767, 16'sd1234, -16'sd2345, 1'b1, 1'b1}, 1'b0, '0},
        '{'{-16'sd32768, -16'sd4000, 16'sd4000, 1'b1, 1'b1}, 1'b0, '0},
        '{'{16'sd6434, 16'sd4095, 16'sd0, 1'b1, 1'b1}, 1'b0, '0},
        '{'{-16'sd1, 16'sd1, -16'sd1, 1'b1, 1'b1}, 1'b0, '0},
        '{'{16'sd1, -16'sd1, 16'sd1, 1'b1, 1'b1}, 1'b0, '0},
        '{'{16'sd100, 16'sd2000, 16'sd2000, 1'b1, 1'b1}, 1'b0, '0},
        '{'{16'sd25735, -16'sd1000, 16'sd3000, 1'b1, 1'b1}, 1'b0, '0},
        '{'{16'sd8000, 16'sd32767, 16'sd32767, 1'b1, 1'b1}, 1'b0, '0}
    };

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [CFG_AW-1:0] paddr;
    logic [CFG_DW-1:0] pwdata;
    logic [CFG_DW-1:0] prdata;
    logic              pready;

    htc_in_if  ref_ch ();
    htc_out_if cmd_ch ();

    t_cfg        steer_cfg;
    t_body_cmd   body_cmd_q [$];
    int unsigned idle_pct;
    int unsigned mismatch_cnt;

    holonomic_track_command u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .i_ref   (ref_ch),
        .o_cmd   (cmd_ch)
    );

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // run limit, far beyond the slowest passing run
    initial begin
        #1000000;
        $display("Some tests failed");
        $finish;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t ns mismatch %s: got %0d, want %0d", $time, what, got, want);
        mismatch_cnt++;
    endtask

    // wrap a q30 angle into [-pi, pi)
    function automatic longint wrap_angle(input longint a);
        longint v;
        v = a;
        while (v >= PI_Q) v -= TWO_PI_Q;
        while (v < -PI_Q) v += TWO_PI_Q;
        return v;
    endfunction

    function automatic longint clamp_abs(input longint v, input longint lim);
        if (v > lim) return lim;
        if (v < -lim) return -lim;
        return v;
    endfunction

    // body-frame speeds and heading rate for one command
    function automatic t_body_cmd rotate_and_steer(input t_ref_cmd c);
        longint    yaw, vx, vy, ang, dx, dy, err, rate, bx, by;
        int        i;
        t_body_cmd r;
        r = '0;
        if (!(c.reference_valid && c.pose_valid)) return r;
        yaw = wrap_angle(longint'($signed(c.pose_yaw)) <<< (30 - FRAC_BITS));
        vx  = longint'($signed(c.ref_vel_x)) <<< VEL_GUARD;
        vy  = longint'($signed(c.ref_vel_y)) <<< VEL_GUARD;
        // fold the rotation into a quarter turn either side of zero
        ang = -yaw;
        if (ang > HALF_PI_Q) begin
            vx = -vx; vy = -vy; ang -= PI_Q;
        end else if (ang < -HALF_PI_Q) begin
            vx = -vx; vy = -vy; ang += PI_Q;
        end
        for (i = 0; i < ROT_STEPS && i < 24; i++) begin
            dx = vy >>> i;
            dy = vx >>> i;
            if (ang >= 0) begin
                vx -= dx; vy += dy; ang -= ATAN_STEP[i];
            end else begin
                vx += dx; vy -= dy; ang += ATAN_STEP[i];
            end
        end
        bx = (vx * INV_K_Q30 + (64'sd1 <<< (29 + VEL_GUARD))) >>> (30 + VEL_GUARD);
        by = (vy * INV_K_Q30 + (64'sd1 <<< (29 + VEL_GUARD))) >>> (30 + VEL_GUARD);
        bx = clamp_abs(bx, longint'(steer_cfg.speed_limit));
        by = clamp_abs(by, longint'(steer_cfg.speed_limit));
        // proportional heading control
        err  = wrap_angle((longint'($signed(steer_cfg.target_heading)) <<< (30 - FRAC_BITS))
                          - yaw);
        rate = (longint'(steer_cfg.heading_gain) * err + (64'sd1 <<< 25)) >>> 26;
        rate = clamp_abs(rate, longint'(steer_cfg.yaw_rate_limit));
        r.body_vel_x   = 16'(bx);
        r.body_vel_y   = 16'(by);
        r.yaw_rate_cmd = 16'(rate);
        return r;
    endfunction

    function automatic t_ref_cmd random_ref();
        t_ref_cmd c;
        if ($urandom_range(0, 7) == 0) c.pose_yaw = 16'($urandom());
        else c.pose_yaw = 16'(int'($urandom_range(0, 51472)) - 25736);
        if ($urandom_range(0, 2) == 0) begin
            c.ref_vel_x = 16'($urandom());
            c.ref_vel_y = 16'($urandom());
        end else begin
            c.ref_vel_x = 16'(int'($urandom_range(0, 12000)) - 6000);
            c.ref_vel_y = 16'(int'($urandom_range(0, 12000)) - 6000);
        end
        c.reference_valid = ($urandom_range(0, 9) != 0);
        c.pose_valid      = ($urandom_range(0, 9) != 0);
        return c;
    endfunction

    function automatic t_cfg random_cfg();
        t_cfg c;
        c.target_heading = 16'(int'($urandom_range(0, 51472)) - 25736);
        c.heading_gain   = 16'($urandom_range(0, 65535));
        c.yaw_rate_limit = 15'($urandom_range(0, 32767));
        c.speed_limit    = 15'($urandom_range(0, 32767));
        return c;
    endfunction

    // apb write: setup cycle, then access cycle until pready
    task automatic cfg_write(input t_reg_idx idx, input logic [CFG_DW-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_TARGET:    steer_cfg.target_heading = data[FIELD_W-1:0];
            REG_GAIN:      steer_cfg.heading_gain   = data[GAIN_W-1:0];
            REG_RATE_LIM:  steer_cfg.yaw_rate_limit = data[LIM_W-1:0];
            REG_SPEED_LIM: steer_cfg.speed_limit    = data[LIM_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // one command transfer, with an occasional idle burst ahead of it
    task automatic send_cmd(input t_ref_cmd c, input logic typed, input t_body_cmd want);
        if ($urandom_range(0, 99) < idle_pct) begin
            ref_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        ref_ch.valid           <= 1'b1;
        ref_ch.pose_yaw        <= c.pose_yaw;
        ref_ch.ref_vel_x       <= c.ref_vel_x;
        ref_ch.ref_vel_y       <= c.ref_vel_y;
        ref_ch.reference_valid <= c.reference_valid;
        ref_ch.pose_valid      <= c.pose_valid;
        do @(posedge i_clk); while (!ref_ch.ready);
        body_cmd_q.push_back(typed ? want : rotate_and_steer(c));
    endtask

    task automatic wait_drained();
        do @(posedge i_clk); while (body_cmd_q.size() != 0);
    endtask

    // new register setting on an idle block, then a run of random commands
    task automatic run_phase(input t_cfg c, input int unsigned pct, input int n_cmds);
        ref_ch.valid <= 1'b0;
        wait_drained();
        cfg_write(REG_TARGET,    {16'($urandom()), c.target_heading});
        cfg_write(REG_GAIN,      {16'($urandom()), c.heading_gain});
        cfg_write(REG_RATE_LIM,  {17'($urandom()), c.yaw_rate_limit});
        cfg_write(REG_SPEED_LIM, {17'($urandom()), c.speed_limit});
        idle_pct = pct;
        repeat (n_cmds) send_cmd(random_ref(), 1'b0, '0);
    endtask

    // result side: random stall bursts while idle_pct allows
    initial begin
        cmd_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if ($urandom_range(0, 99) < idle_pct) begin
                cmd_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge i_clk);
            end
            cmd_ch.ready <= 1'b1;
        end
    end

    // check each result transfer against the oldest expectation
    always @(posedge i_clk) begin
        t_body_cmd want;
        if (i_rst_n && cmd_ch.valid && cmd_ch.ready) begin
            if (body_cmd_q.size() == 0) begin
                report_mismatch("result with none expected", cmd_ch.body_vel_x, 0);
            end else begin
                want = body_cmd_q.pop_front();
                if (cmd_ch.body_vel_x !== want.body_vel_x)
                    report_mismatch("body_vel_x", cmd_ch.body_vel_x, want.body_vel_x);
                if (cmd_ch.body_vel_y !== want.body_vel_y)
                    report_mismatch("body_vel_y", cmd_ch.body_vel_y, want.body_vel_y);
                if (cmd_ch.yaw_rate_cmd !== want.yaw_rate_cmd)
                    report_mismatch("yaw_rate_cmd", cmd_ch.yaw_rate_cmd, want.yaw_rate_cmd);
            end
        end
    end

    // main sequence
    initial begin
        mismatch_cnt           = 0;
        idle_pct               = 20;
        steer_cfg              = CFG_RST;
        i_rst_n               <= 1'b0;
        psel                  <= 1'b0;
        penable               <= 1'b0;
        pwrite                <= 1'b0;
        paddr                 <= '0;
        pwdata                <= '0;
        ref_ch.valid          <= 1'b0;
        ref_ch.pose_yaw       <= '0;
        ref_ch.ref_vel_x      <= '0;
        ref_ch.ref_vel_y      <= '0;
        ref_ch.reference_valid <= 1'b0;
        ref_ch.pose_valid     <= 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed rows, then random commands, on reset values
        for (int n = 0; n < DIR_ROWS; n++)
            send_cmd(DIRECTED[n].cmd, DIRECTED[n].typed, DIRECTED[n].want);
        repeat (100) send_cmd(random_ref(), 1'b0, '0);

        // register settings, extremes among them
        run_phase('{target_heading: 16'sd25736, heading_gain: 16'd65535,
                    yaw_rate_limit: 15'd32767, speed_limit: 15'd32767}, 25, 90);
        run_phase('{target_heading: -16'sd25736, heading_gain: 16'd0,
                    yaw_rate_limit: 15'd0, speed_limit: 15'd0}, 0, 60);
        run_phase(random_cfg(), 40, 90);
        run_phase('{target_heading: 16'sd0, heading_gain: 16'd1,
                    yaw_rate_limit: 15'd1, speed_limit: 15'd1}, 15, 60);
        run_phase(random_cfg(), 30, 90);
        // last stretch without idling
        run_phase(random_cfg(), 0, 90);

        ref_ch.valid <= 1'b0;
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_cnt == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

[filelist.f]
src/htc_pkg.sv
src/htc_in_if.sv
src/htc_out_if.sv
src/htc_cfg.sv
src/htc_wrap.sv
src/htc_cordic.sv
src/htc_heading.sv
src/holonomic_track_command.sv
bench/tb_top.sv
